FILE: hdl/multi_button_event_qualifier_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MULTI_BUTTON_EVENT_QUALIFIER_CORE_ASSERT_SVH
`define MULTI_BUTTON_EVENT_QUALIFIER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MBEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MBEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/mbeq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbeq_pkg
// Types, constants and helpers for the button event qualifier.
// ---------------------------------------------------------------------------
package mbeq_pkg;
    localparam int NUM_BUTTONS = 3;
    localparam int MAX_EVENTS  = 8;
    localparam int BTN_W       = 2;
    localparam int CNT_W       = $clog2(MAX_EVENTS + 1);
    localparam int QDEPTH      = 2;
    localparam int OQ_DEPTH    = 4;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_INJECT = 2'd1,
        CMD_COMBO_CLR = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PRESS   = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_REPEAT  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_ACTIVE_LOW = 3'd0,
        REG_DEBOUNCE   = 3'd1,
        REG_CANDIDATE  = 3'd2,
        REG_LONG       = 3'd3,
        REG_REP_DELAY  = 3'd4,
        REG_REP_INTVL  = 3'd5,
        REG_COMBO_HOLD = 3'd6,
        REG_UNUSED     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        active_low;
        logic [15:0] debounce_ms;
        logic [15:0] candidate_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_delay_ms;
        logic [15:0] repeat_interval_ms;
        logic [15:0] combo_hold_ms;
    } cfg_t;

    // Classified request handed from the front to the back part.
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] now;
        logic [2:0]  raw;
        logic        inj_ok;
        logic [1:0]  inj_button;
        logic [2:0]  inj_type;
        logic [15:0] inj_duration;
    } req_t;

    typedef struct packed {
        logic [1:0]  button;
        logic [2:0]  kind;
        logic [31:0] time_ms;
        logic [15:0] duration;
        logic        last;
        logic [2:0]  mask;
        logic        combo_active;
        logic        combo_done;
        logic [31:0] combo_held;
    } evt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEBOUNCE,
        ST_COMBO,
        ST_CAND,
        ST_BUTTON,
        ST_FLUSH
    } state_t;
endpackage

FILE: hdl/multi_button_event_qualifier_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_button_event_qualifier_core
// Debounces buttons and emits press, release, long press and repeat events.
// ---------------------------------------------------------------------------
// A sample request passes through the back-end states in order: it is taken
// in idle, then debounce, combo tracking and the suppression check, then one
// button step per button, then one flush step per result written into the
// output queue (at least one, at most eight). When events are suppressed the
// button pass ends after its first step. Inject, combo-clear and unused
// requests go from idle straight to the flush. A full output queue stretches
// the result writes. A new request is taken only once the last one has been
// flushed. Requests are buffered in a two-entry queue and results in a
// four-entry queue.
module multi_button_event_qualifier_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [31:0] now_ms,
    input  logic [2:0]  raw_levels,
    input  logic [1:0]  inject_button,
    input  logic [2:0]  inject_type,
    input  logic [15:0] inject_duration,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_button,
    output logic [2:0]  event_kind,
    output logic [31:0] event_time,
    output logic [15:0] event_duration,
    output logic        last,
    output logic [2:0]  pressed_mask,
    output logic        combo_active,
    output logic        combo_done,
    output logic [31:0] combo_held_ms
);
    import mbeq_pkg::*;

    cfg_t cfg_reg;
    logic req_valid, req_take;
    req_t req;
    evt_t evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low <= 1'b1;
            cfg_reg.debounce_ms <= 16'd20;
            cfg_reg.candidate_ms <= 16'd50;
            cfg_reg.long_press_ms <= 16'd800;
            cfg_reg.repeat_delay_ms <= 16'd300;
            cfg_reg.repeat_interval_ms <= 16'd150;
            cfg_reg.combo_hold_ms <= 16'd5000;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ACTIVE_LOW: cfg_reg.active_low <= cfg_data[0];
                REG_DEBOUNCE:   cfg_reg.debounce_ms <= cfg_data;
                REG_CANDIDATE:  cfg_reg.candidate_ms <= cfg_data;
                REG_LONG:       cfg_reg.long_press_ms <= cfg_data;
                REG_REP_DELAY:  cfg_reg.repeat_delay_ms <= cfg_data;
                REG_REP_INTVL:  cfg_reg.repeat_interval_ms <= cfg_data;
                REG_COMBO_HOLD: cfg_reg.combo_hold_ms <= cfg_data;
                REG_UNUSED:     ;
                default:        ;
            endcase
        end
    end

    mbeq_front u_front (
        .clk, .rst_n, .push, .full, .command, .now_ms, .raw_levels,
        .inject_button, .inject_type, .inject_duration,
        .req_valid, .req, .req_take
    );

    mbeq_back u_back (
        .clk, .rst_n, .cfg(cfg_reg), .req_valid, .req, .req_take,
        .empty, .pop, .evt
    );

    assign event_button = evt.button;
    assign event_kind = evt.kind;
    assign event_time = evt.time_ms;
    assign event_duration = evt.duration;
    assign last = evt.last;
    assign pressed_mask = evt.mask;
    assign combo_active = evt.combo_active;
    assign combo_done = evt.combo_done;
    assign combo_held_ms = evt.combo_held;
endmodule

FILE: hdl/mbeq_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbeq_front
// Accepts requests, validates injections and queues them for the back part.
// ---------------------------------------------------------------------------
module mbeq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic [31:0]         now_ms,
    input  logic [2:0]          raw_levels,
    input  logic [1:0]          inject_button,
    input  logic [2:0]          inject_type,
    input  logic [15:0]         inject_duration,
    output logic                req_valid,
    output mbeq_pkg::req_t      req,
    input  logic                req_take
);
    import mbeq_pkg::*;

    req_t q_reg [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    req_t in_req;
    logic do_push, do_pop;

    always_comb
    begin
        in_req.cmd = cmd_t'(command);
        in_req.now = now_ms;
        in_req.raw = raw_levels;
        in_req.inj_ok = (inject_button < 2'(NUM_BUTTONS)) &&
                        (inject_type >= KIND_PRESS) && (inject_type <= KIND_REPEAT);
        in_req.inj_button = inject_button;
        in_req.inj_type = inject_type;
        in_req.inj_duration = inject_duration;
    end

    assign full = (cnt_reg == 2'(QDEPTH));
    assign req_valid = (cnt_reg != 2'd0);
    assign req = q_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop = req_take && req_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wp_reg <= wp_reg + 1'b1;
            if (do_pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

FILE: hdl/mbeq_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbeq_back
// Runs debounce, combo tracking and per-button event generation, one button
// a cycle, and queues the resulting events.
// ---------------------------------------------------------------------------
module mbeq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mbeq_pkg::cfg_t cfg,
    input  logic           req_valid,
    input  mbeq_pkg::req_t req,
    output logic           req_take,
    output logic           empty,
    input  logic           pop,
    output mbeq_pkg::evt_t evt
);
    import mbeq_pkg::*;

    logic [NUM_BUTTONS-1:0] stable_reg, prev_reg, long_reg, rbeg_reg, sent_reg;
    logic [31:0] change_reg [NUM_BUTTONS];
    logic [31:0] pstart_reg [NUM_BUTTONS];
    logic [31:0] rtime_reg  [NUM_BUTTONS];
    logic        call_reg, cfired_reg;
    logic [31:0] cstart_reg;

    state_t state_reg, state_next;
    logic [BTN_W-1:0] bi_reg;
    req_t  cur_reg;
    logic  supp_reg, incand_reg;
    // Event list of the current request.
    evt_t  ev_reg [MAX_EVENTS];
    logic [CNT_W-1:0] ecnt_reg, fi_reg;

    // Output queue.
    evt_t  oq_reg [OQ_DEPTH];
    logic [1:0] owp_reg, orp_reg;
    logic [2:0] ocnt_reg;
    logic  oq_full, oq_push, oq_pop;

    logic [31:0] now;
    assign now = cur_reg.now;

    assign req_take = (state_reg == ST_IDLE) && req_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid) state_next = (req.cmd == CMD_SAMPLE) ? ST_DEBOUNCE : ST_FLUSH;
            ST_DEBOUNCE: state_next = ST_COMBO;
            ST_COMBO:    state_next = ST_CAND;
            ST_CAND:     state_next = ST_BUTTON;
            ST_BUTTON:
                if (supp_reg || bi_reg == BTN_W'(NUM_BUTTONS - 1)) state_next = ST_FLUSH;
            ST_FLUSH:
                if (!oq_full && (fi_reg + 1'b1 >= ecnt_reg || ecnt_reg == '0))
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Per-button debounce inputs.
    logic [NUM_BUTTONS-1:0] down;
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            down[i] = (i < 3) ? (cur_reg.raw[i] ^ cfg.active_low) : cfg.active_low;
        end
    end

    // Candidate search, done on registered state.
    logic [31:0] earliest;
    logic [3:0]  ndown;
    always_comb
    begin
        earliest = now;
        ndown = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (stable_reg[i])
            begin
                ndown = ndown + 4'd1;
                if (pstart_reg[i] < earliest) earliest = pstart_reg[i];
            end
        end
    end

    // Button step.
    logic [31:0] held, since_press, since_rep;
    logic        st, pv, ps, lf, rb;
    logic        e_press, e_rel, e_long, e_rep, n_sent, n_long, n_rbeg, n_prev;
    logic        set_start, set_rtime;
    logic [16:0] lr_sum;
    always_comb
    begin
        st = stable_reg[bi_reg];
        pv = prev_reg[bi_reg];
        ps = sent_reg[bi_reg];
        lf = long_reg[bi_reg];
        rb = rbeg_reg[bi_reg];
        held = now - pstart_reg[bi_reg];
        since_press = held;
        since_rep = now - rtime_reg[bi_reg];
        lr_sum = {1'b0, cfg.long_press_ms} + {1'b0, cfg.repeat_delay_ms};
        e_press = 1'b0; e_rel = 1'b0; e_long = 1'b0; e_rep = 1'b0;
        n_sent = ps; n_long = lf; n_rbeg = rb; n_prev = pv;
        set_start = 1'b0; set_rtime = 1'b0;
        priority if (st && !pv)
        begin
            set_start = 1'b1; n_long = 1'b0; n_rbeg = 1'b0; n_sent = 1'b0; n_prev = 1'b1;
        end
        else if (!st && pv)
        begin
            e_press = !ps; n_sent = 1'b1; e_rel = 1'b1; n_prev = 1'b0;
        end
        else if (st)
        begin
            if (!ps && !incand_reg && since_press >= {16'd0, cfg.candidate_ms})
            begin
                e_press = 1'b1; n_sent = 1'b1;
            end
            if (n_sent && !lf && held >= {16'd0, cfg.long_press_ms})
            begin
                n_long = 1'b1; e_long = 1'b1;
            end
            if (n_long)
            begin
                if (!rb)
                begin
                    if (held >= {15'd0, lr_sum})
                    begin
                        n_rbeg = 1'b1; set_rtime = 1'b1; e_rep = 1'b1;
                    end
                end
                else if (since_rep >= {16'd0, cfg.repeat_interval_ms})
                begin
                    set_rtime = 1'b1; e_rep = 1'b1;
                end
            end
        end
        else
        begin
            n_prev = pv;
        end
    end

    // Slots for events generated this cycle, in order.
    evt_t ev_new [4];
    logic [3:0] ev_en;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ev_new[k] = '0;
            ev_new[k].button = bi_reg;
        end
        ev_en = {e_rep, e_long, e_rel, e_press};
        ev_new[0].kind = KIND_PRESS;   ev_new[0].time_ms = pstart_reg[bi_reg];
        ev_new[1].kind = KIND_RELEASE; ev_new[1].time_ms = now;
        ev_new[1].duration = held[15:0];
        ev_new[2].kind = KIND_LONG;    ev_new[2].time_ms = now;
        ev_new[2].duration = held[15:0];
        ev_new[3].kind = KIND_REPEAT;  ev_new[3].time_ms = now;
        ev_new[3].duration = held[15:0];
    end

    // Positions in the event list for this cycle's events; the rest are dropped.
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] slot [4];
    logic [3:0]       slot_en;
    logic [CNT_W-1:0] ecnt_next;
    always_comb
    begin
        c = ecnt_reg;
        for (int k = 0; k < 4; k++)
        begin
            slot[k] = c;
            slot_en[k] = ev_en[k] && (c < CNT_W'(MAX_EVENTS));
            if (slot_en[k]) c = c + 1'b1;
        end
        ecnt_next = c;
    end

    // Outgoing record with status filled in.
    evt_t out_ev;
    always_comb
    begin
        if (ecnt_reg == '0)
            out_ev = '0;
        else
            out_ev = ev_reg[fi_reg[CNT_W-1:0] < CNT_W'(MAX_EVENTS) ?
                            fi_reg[$clog2(MAX_EVENTS)-1:0] : '0];
        out_ev.last = (ecnt_reg == '0) || (fi_reg + 1'b1 >= ecnt_reg);
        out_ev.mask = stable_reg;
        out_ev.combo_active = call_reg;
        out_ev.combo_done = cfired_reg;
        out_ev.combo_held = call_reg ? (now - cstart_reg) : 32'd0;
    end

    // Candidate evaluated on the state as the next button step will see it.
    logic [31:0] earliest_next;
    logic [3:0]  ndown_next;
    always_comb
    begin
        earliest_next = earliest;
        ndown_next = ndown;
        if (state_reg == ST_BUTTON && set_start)
        begin
            earliest_next = now;
            ndown_next = ndown;
            for (int i = 0; i < NUM_BUTTONS; i++)
                if (stable_reg[i] && BTN_W'(i) != bi_reg && pstart_reg[i] < earliest_next)
                    earliest_next = pstart_reg[i];
        end
    end

    assign oq_full = (ocnt_reg == 3'(OQ_DEPTH));
    assign oq_push = (state_reg == ST_FLUSH) && !oq_full;
    assign oq_pop = pop && !empty;
    assign empty = (ocnt_reg == 3'd0);
    assign evt = oq_reg[orp_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push) oq_reg[owp_reg] <= out_ev;
        if (req_take) cur_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stable_reg <= '0; prev_reg <= '0; long_reg <= '0; rbeg_reg <= '0; sent_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                change_reg[i] <= '0; pstart_reg[i] <= '0; rtime_reg[i] <= '0;
            end
            call_reg <= 1'b0; cfired_reg <= 1'b0; cstart_reg <= '0;
            bi_reg <= '0; supp_reg <= 1'b0; incand_reg <= 1'b0;
            ecnt_reg <= '0; fi_reg <= '0;
            owp_reg <= '0; orp_reg <= '0; ocnt_reg <= '0;
            for (int k = 0; k < MAX_EVENTS; k++) ev_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (oq_push) owp_reg <= owp_reg + 2'd1;
            if (oq_pop) orp_reg <= orp_reg + 2'd1;
            ocnt_reg <= ocnt_reg + {2'b0, oq_push} - {2'b0, oq_pop};
            unique case (state_reg)
                ST_IDLE:
                begin
                    ecnt_reg <= '0; fi_reg <= '0; bi_reg <= '0;
                    if (req_valid && req.cmd == CMD_INJECT && req.inj_ok)
                    begin
                        ev_reg[0].button <= req.inj_button;
                        ev_reg[0].kind <= req.inj_type;
                        ev_reg[0].time_ms <= req.now;
                        ev_reg[0].duration <= req.inj_duration;
                        ecnt_reg <= CNT_W'(1);
                    end
                    if (req_valid && req.cmd == CMD_COMBO_CLR)
                    begin
                        call_reg <= 1'b0; cstart_reg <= '0; cfired_reg <= 1'b0;
                    end
                end
                ST_DEBOUNCE:
                begin
                    for (int i = 0; i < NUM_BUTTONS; i++)
                    begin
                        if (down[i] != stable_reg[i])
                        begin
                            if (now - change_reg[i] >= {16'd0, cfg.debounce_ms})
                            begin
                                prev_reg[i] <= stable_reg[i];
                                stable_reg[i] <= down[i];
                                change_reg[i] <= now;
                            end
                        end
                        else
                        begin
                            change_reg[i] <= now;
                        end
                    end
                end
                ST_COMBO:
                begin
                    if (&stable_reg)
                    begin
                        if (!call_reg)
                        begin
                            call_reg <= 1'b1; cstart_reg <= now; cfired_reg <= 1'b0;
                        end
                        else if (!cfired_reg && (now - cstart_reg >= {16'd0, cfg.combo_hold_ms}))
                            cfired_reg <= 1'b1;
                    end
                    else if (call_reg)
                    begin
                        call_reg <= 1'b0;
                        if (!cfired_reg) cstart_reg <= '0;
                    end
                end
                ST_CAND:
                begin
                    supp_reg <= cfired_reg ||
                        (call_reg && (now - cstart_reg > {16'd0, cfg.candidate_ms}));
                end
                ST_BUTTON:
                begin
                    if (!supp_reg)
                    begin
                        prev_reg[bi_reg] <= n_prev;
                        sent_reg[bi_reg] <= n_sent;
                        long_reg[bi_reg] <= n_long;
                        rbeg_reg[bi_reg] <= n_rbeg;
                        if (set_start) pstart_reg[bi_reg] <= now;
                        if (set_rtime) rtime_reg[bi_reg] <= now;
                        for (int k = 0; k < 4; k++)
                        begin
                            if (slot_en[k])
                                ev_reg[slot[k][$clog2(MAX_EVENTS)-1:0]] <= ev_new[k];
                        end
                        ecnt_reg <= ecnt_next;
                        bi_reg <= bi_reg + 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    if (oq_push) fi_reg <= fi_reg + 1'b1;
                end
                default: ;
            endcase
            // Refresh the candidate flag before each button step.
            if (state_next == ST_BUTTON)
                incand_reg <= (ndown_next >= 4'd2) && (now - earliest_next < {16'd0, cfg.candidate_ms});
        end
    end
endmodule

FILE: hdl/mbeq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbeq_checker
// Port-level checks on the event qualifier.
// ---------------------------------------------------------------------------
`include "multi_button_event_qualifier_core_assert.svh"
module mbeq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  event_kind,
    input logic [15:0] event_duration,
    input logic        last,
    input logic        combo_active,
    input logic [31:0] combo_held_ms
);
    import mbeq_pkg::*;

    `MBEQ_ASSERT_IMPL(a_kind_range, clk, rst_n, !empty, event_kind <= KIND_REPEAT, "bad event kind")
    `MBEQ_ASSERT_IMPL(a_none_last, clk, rst_n, !empty && event_kind == KIND_NONE, last && event_duration == 16'd0, "none result not last")
    `MBEQ_ASSERT_IMPL(a_held_zero, clk, rst_n, !empty && !combo_active, combo_held_ms == 32'd0, "held time without combo")
    `MBEQ_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty, "result withdrawn")
endmodule

bind multi_button_event_qualifier_core mbeq_checker u_chk (
    .clk, .rst_n, .empty, .pop, .event_kind, .event_duration, .last,
    .combo_active, .combo_held_ms
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button event qualifier testbench
// Drives sample, inject, combo-clear and unused requests through the input queue,
// predicts the event stream of every request and compares it field by field
// with what the result queue delivers, under random back-pressure.
// ---------------------------------------------------------------------------
module tb;
    import mbeq_pkg::*;

    localparam int NB = NUM_BUTTONS;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic [2:0]  raw_levels;
        logic [1:0]  inject_button;
        logic [2:0]  inject_type;
        logic [15:0] inject_duration;
    } request_t;

    typedef struct packed {
        logic [1:0]  button;
        logic [2:0]  kind;
        logic [31:0] time_ms;
        logic [15:0] duration;
        logic        last;
        logic [2:0]  mask;
        logic        combo_active;
        logic        combo_done;
        logic [31:0] combo_held;
    } event_rec_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  command = 2'd0;
    logic [31:0] now_ms = 32'd0;
    logic [2:0]  raw_levels = 3'd0;
    logic [1:0]  inject_button = 2'd0;
    logic [2:0]  inject_type = 3'd0;
    logic [15:0] inject_duration = 16'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  event_button;
    logic [2:0]  event_kind;
    logic [31:0] event_time;
    logic [15:0] event_duration;
    logic        last;
    logic [2:0]  pressed_mask;
    logic        combo_active;
    logic        combo_done;
    logic [31:0] combo_held_ms;

    multi_button_event_qualifier_core u_dut (.*);

    // Predictor state
    logic        m_active_low;
    logic [31:0] m_debounce, m_candidate, m_long, m_rep_delay, m_rep_intvl, m_combo_hold;
    logic        stable_lv[NB], prev_stable[NB], long_done[NB], rep_started[NB], press_out[NB];
    logic [31:0] change_t[NB], press_t[NB], rep_t[NB];
    logic        all_down, combo_latched;
    logic [31:0] combo_t;

    event_rec_t  step_events[$];
    event_rec_t  expected_events[$];
    request_t    pending_requests[$];

    int          errors = 0;
    int          events_seen = 0;
    int          requests_sent = 0;
    longint      cycle_count = 0;
    bit          quiet_mode = 0;
    int          send_gap = 0;
    int          pop_gap = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (event %0d)", what, got, want,
                 events_seen);
    endtask

    function automatic void add_event(input logic [1:0] b, input logic [2:0] k,
                                      input logic [31:0] t, input logic [31:0] d);
        event_rec_t e;
        if (step_events.size() >= MAX_EVENTS) return;
        e = '0;
        e.button = b;
        e.kind = k;
        e.time_ms = t;
        e.duration = d[15:0];
        step_events.push_back(e);
    endfunction

    function automatic void write_model_reg(input reg_idx_t idx, input logic [15:0] v);
        case (idx)
            REG_ACTIVE_LOW: m_active_low = v[0];
            REG_DEBOUNCE:   m_debounce = {16'd0, v};
            REG_CANDIDATE:  m_candidate = {16'd0, v};
            REG_LONG:       m_long = {16'd0, v};
            REG_REP_DELAY:  m_rep_delay = {16'd0, v};
            REG_REP_INTVL:  m_rep_intvl = {16'd0, v};
            REG_COMBO_HOLD: m_combo_hold = {16'd0, v};
            default: ;
        endcase
    endfunction

    function automatic bit window_open(input logic [31:0] t);
        int cnt;
        logic [31:0] earliest;
        cnt = 0;
        earliest = t;
        for (int i = 0; i < NB; i++) if (stable_lv[i]) cnt++;
        if (cnt < 2) return 0;
        for (int i = 0; i < NB; i++)
            if (stable_lv[i] && press_t[i] < earliest) earliest = press_t[i];
        return (t - earliest) < m_candidate;
    endfunction

    function automatic void predict_sample(input logic [31:0] t, input logic [2:0] raw);
        logic down, all;
        logic [31:0] held;
        for (int i = 0; i < NB; i++) begin
            down = m_active_low ? !raw[i] : raw[i];
            if (down != stable_lv[i]) begin
                if (t - change_t[i] >= m_debounce) begin
                    prev_stable[i] = stable_lv[i];
                    stable_lv[i] = down;
                    change_t[i] = t;
                end
            end else begin
                change_t[i] = t;
            end
        end
        all = 1;
        for (int i = 0; i < NB; i++) if (!stable_lv[i]) all = 0;
        if (all) begin
            if (!all_down) begin
                all_down = 1;
                combo_t = t;
                combo_latched = 0;
            end else if (!combo_latched && (t - combo_t >= m_combo_hold)) begin
                combo_latched = 1;
            end
        end else if (all_down) begin
            all_down = 0;
            if (!combo_latched) combo_t = 0;
        end
        if (combo_latched || (all_down && (t - combo_t) > m_candidate)) return;
        for (int i = 0; i < NB; i++) begin
            if (stable_lv[i] && !prev_stable[i]) begin
                press_t[i] = t;
                long_done[i] = 0;
                rep_started[i] = 0;
                press_out[i] = 0;
                prev_stable[i] = 1;
            end else if (!stable_lv[i] && prev_stable[i]) begin
                if (!press_out[i]) begin
                    add_event(2'(i), KIND_PRESS, press_t[i], 32'd0);
                    press_out[i] = 1;
                end
                add_event(2'(i), KIND_RELEASE, t, t - press_t[i]);
                prev_stable[i] = 0;
            end else if (stable_lv[i]) begin
                if (!press_out[i] && !window_open(t) && (t - press_t[i]) >= m_candidate) begin
                    add_event(2'(i), KIND_PRESS, press_t[i], 32'd0);
                    press_out[i] = 1;
                end
                held = t - press_t[i];
                if (press_out[i] && !long_done[i] && held >= m_long) begin
                    long_done[i] = 1;
                    add_event(2'(i), KIND_LONG, t, held);
                end
                if (long_done[i]) begin
                    if (!rep_started[i]) begin
                        if (held >= m_long + m_rep_delay) begin
                            rep_started[i] = 1;
                            rep_t[i] = t;
                            add_event(2'(i), KIND_REPEAT, t, held);
                        end
                    end else if (t - rep_t[i] >= m_rep_intvl) begin
                        rep_t[i] = t;
                        add_event(2'(i), KIND_REPEAT, t, held);
                    end
                end
            end
        end
    endfunction

    function automatic void predict_request(input request_t r);
        logic [2:0] mask;
        event_rec_t e;
        step_events.delete();
        case (cmd_t'(r.command))
            CMD_SAMPLE: predict_sample(r.now_ms, r.raw_levels);
            CMD_INJECT:
                if (r.inject_button < NB && r.inject_type >= KIND_PRESS
                    && r.inject_type <= KIND_REPEAT)
                    add_event(r.inject_button, r.inject_type, r.now_ms,
                              {16'd0, r.inject_duration});
            CMD_COMBO_CLR: begin
                all_down = 0;
                combo_t = 0;
                combo_latched = 0;
            end
            default: ;
        endcase
        if (step_events.size() == 0) add_event(2'd0, KIND_NONE, 32'd0, 32'd0);
        mask = '0;
        for (int i = 0; i < NB; i++) mask[i] = stable_lv[i];
        foreach (step_events[k]) begin
            e = step_events[k];
            e.last = (k == step_events.size() - 1);
            e.mask = mask;
            e.combo_active = all_down;
            e.combo_done = combo_latched;
            e.combo_held = all_down ? r.now_ms - combo_t : 32'd0;
            expected_events.push_back(e);
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: presents the oldest pending request and predicts it on acceptance.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 0;
            send_gap <= 0;
        end else begin
            if (push && !full) begin
                predict_request(pending_requests.pop_front());
                requests_sent <= requests_sent + 1;
            end
            if (push && full) begin
                // hold the current request
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                push <= 0;
            end else if (pending_requests.size() > 0 &&
                         !(push && !full && pending_requests.size() == 0)) begin
                if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 19);
                    push <= 0;
                end else begin
                    push <= 1;
                    command <= pending_requests[0].command;
                    now_ms <= pending_requests[0].now_ms;
                    raw_levels <= pending_requests[0].raw_levels;
                    inject_button <= pending_requests[0].inject_button;
                    inject_type <= pending_requests[0].inject_type;
                    inject_duration <= pending_requests[0].inject_duration;
                end
            end else begin
                push <= 0;
            end
        end
    end

    // Monitor: pops results under random stalls and checks them in order.
    always @(posedge clk or negedge rst_n) begin
        event_rec_t want;
        if (!rst_n) begin
            pop <= 0;
            pop_gap <= 0;
        end else begin
            if (pop && !empty) begin
                events_seen <= events_seen + 1;
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event", {29'd0, event_kind}, 32'd0);
                end else begin
                    want = expected_events.pop_front();
                    if (event_button !== want.button)
                        report_mismatch("event_button", 32'(event_button), 32'(want.button));
                    if (event_kind !== want.kind)
                        report_mismatch("event_kind", 32'(event_kind), 32'(want.kind));
                    if (event_time !== want.time_ms)
                        report_mismatch("event_time", event_time, want.time_ms);
                    if (event_duration !== want.duration)
                        report_mismatch("event_duration", 32'(event_duration),
                                        32'(want.duration));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                    if (pressed_mask !== want.mask)
                        report_mismatch("pressed_mask", 32'(pressed_mask), 32'(want.mask));
                    if (combo_active !== want.combo_active)
                        report_mismatch("combo_active", 32'(combo_active),
                                        32'(want.combo_active));
                    if (combo_done !== want.combo_done)
                        report_mismatch("combo_done", 32'(combo_done), 32'(want.combo_done));
                    if (combo_held_ms !== want.combo_held)
                        report_mismatch("combo_held_ms", combo_held_ms, want.combo_held);
                end
            end
            if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop <= 0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                pop_gap <= $urandom_range(1, 19);
                pop <= 0;
            end else begin
                pop <= 1;
            end
        end
    end

    logic [31:0] clock_ms;

    function automatic void queue_request(input logic [1:0] c, input logic [2:0] raw,
                                          input logic [1:0] b, input logic [2:0] k,
                                          input logic [15:0] d);
        request_t r;
        r.command = c;
        r.now_ms = clock_ms;
        r.raw_levels = raw;
        r.inject_button = b;
        r.inject_type = k;
        r.inject_duration = d;
        pending_requests.push_back(r);
    endfunction

    function automatic void queue_sample(input logic [2:0] raw, input int step);
        queue_request(CMD_SAMPLE, raw, 2'($urandom), 3'($urandom), 16'($urandom));
        clock_ms = clock_ms + step;
    endfunction

    task automatic drain();
        while (pending_requests.size() != 0 || push) @(posedge clk);
        while (expected_events.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        write_model_reg(idx, v);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic program_all(input logic al, input logic [15:0] deb, input logic [15:0] cand,
                               input logic [15:0] lp, input logic [15:0] rd,
                               input logic [15:0] ri, input logic [15:0] ch);
        set_reg(REG_ACTIVE_LOW, {15'd0, al});
        set_reg(REG_DEBOUNCE, deb);
        set_reg(REG_CANDIDATE, cand);
        set_reg(REG_LONG, lp);
        set_reg(REG_REP_DELAY, rd);
        set_reg(REG_REP_INTVL, ri);
        set_reg(REG_COMBO_HOLD, ch);
    endtask

    // Random press sequences: hold a button set for a while, then release it.
    task automatic random_phase(input int n, input logic al);
        logic [2:0] held_set;
        int len;
        int k;
        k = 0;
        while (k < n) begin
            held_set = 3'($urandom);
            len = $urandom_range(2, 12);
            for (int j = 0; j < len && k < n; j++, k++) begin
                case ($urandom_range(0, 19))
                    0: queue_request(CMD_INJECT, 3'($urandom), 2'($urandom), 3'($urandom),
                                     16'($urandom));
                    1: queue_request(CMD_COMBO_CLR, 3'($urandom), 2'd0, 3'd0, 16'd0);
                    2: queue_request(CMD_NOP, 3'($urandom), 2'($urandom), 3'($urandom),
                                     16'($urandom));
                    3: queue_sample(3'($urandom), $urandom_range(0, 40));
                    4: clock_ms = clock_ms + $urandom;
                    default: queue_sample(al ? ~held_set : held_set,
                                          $urandom_range(0, 3) == 0 ?
                                          $urandom_range(100, 2000) : $urandom_range(1, 120));
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_ACTIVE_LOW;
        cfg_data = 0;
        m_active_low = 1; m_debounce = 20; m_candidate = 50; m_long = 800;
        m_rep_delay = 300; m_rep_intvl = 150; m_combo_hold = 5000;
        for (int i = 0; i < NB; i++) begin
            stable_lv[i] = 0; prev_stable[i] = 0; long_done[i] = 0; rep_started[i] = 0;
            press_out[i] = 0; change_t[i] = 0; press_t[i] = 0; rep_t[i] = 0;
        end
        all_down = 0; combo_t = 0; combo_latched = 0;
        clock_ms = 100;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // Directed: reset values, single press with long press and repeats, a combo,
        // every inject kind and the invalid ones, combo clear and the unused command.
        queue_sample(3'b111, 30);
        queue_sample(3'b110, 30);
        queue_sample(3'b110, 100);
        queue_sample(3'b110, 900);
        queue_sample(3'b110, 300);
        queue_sample(3'b110, 200);
        queue_sample(3'b111, 30);
        queue_sample(3'b000, 30);
        queue_sample(3'b000, 60);
        queue_sample(3'b000, 6000);
        queue_sample(3'b000, 10);
        queue_request(CMD_COMBO_CLR, 3'd0, 2'd0, 3'd0, 16'd0);
        queue_sample(3'b111, 30);
        queue_sample(3'b111, 30);
        for (int k = KIND_PRESS; k <= KIND_REPEAT; k++)
            queue_request(CMD_INJECT, 3'd0, 2'(k - 1), 3'(k), 16'hFFFF);
        queue_request(CMD_INJECT, 3'd0, 2'd3, KIND_PRESS, 16'h1234);
        queue_request(CMD_INJECT, 3'd0, 2'd0, KIND_NONE, 16'd0);
        queue_request(CMD_INJECT, 3'd0, 2'd1, 3'd7, 16'd0);
        queue_request(CMD_NOP, 3'b010, 2'd0, 3'd0, 16'd0);
        clock_ms = 32'hFFFF_FFF0;
        queue_sample(3'b000, 40);
        queue_sample(3'b000, 40);
        drain();

        random_phase(80, 1);
        // Sender pause: every expected event has arrived before the next phase.
        drain();

        program_all(0, 0, 0, 0, 0, 1, 0);
        random_phase(60, 0);
        drain();
        program_all(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(30, 1);
        drain();
        program_all(0, 5, 40, 200, 100, 30, 400);
        random_phase(70, 0);
        drain();
        quiet_mode = 1;
        random_phase(40, 0);
        drain();
        repeat (50) @(posedge clk);

        $display("Sent %0d requests and checked %0d events over four register settings.",
                 requests_sent, events_seen);
        if (errors == 0 && expected_events.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
